@@ src/shrb_pkg.sv @@
// ============================================================================
// shrb_pkg: shared types and constants of the sampled history ring buffer
// Field widths, status and action codes, controller states and the constant
// reciprocal used to split a time of day into hours, minutes and seconds.
// ============================================================================
`default_nettype none

package shrb_pkg;

  localparam int unsigned DEPTH_DEF = 128;

  localparam int unsigned ID_W     = 8;
  localparam int unsigned TIME_W   = 17;
  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned HUM_W    = 10;
  localparam int unsigned IDX_W    = 7;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned SEC_W    = 6;
  localparam int unsigned FILL_W   = 8;
  localparam int unsigned MTOT_W   = 11;  // minutes since midnight, up to 1439

  localparam int unsigned DAY_HALF_SECONDS = 43200;
  localparam int unsigned LAST_TIME_OF_DAY = 86399;
  localparam int unsigned SECONDS_PER_MIN  = 60;

  // Division by 60 as a multiply by ceil(2^24 / 60) and a shift by 24.
  // The error stays below the smallest fraction step for values < 2^17.
  localparam int unsigned DIV60_SHIFT = 24;
  localparam int unsigned DIV60_MUL_W = 19;
  localparam logic [DIV60_MUL_W-1:0] DIV60_MUL = 19'd279621;

  localparam logic ACT_PACKET = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_STORED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_SOON = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic                     action;
    logic [ID_W-1:0]          sender_id;
    logic [TIME_W-1:0]        time_of_day;
    logic signed [TEMP_W-1:0] outside_temp;
    logic signed [TEMP_W-1:0] inside_temp;
    logic [HUM_W-1:0]         inside_humidity;
    logic [IDX_W-1:0]         read_age;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]          rec_id;
    logic [TIME_W-1:0]        rec_time;
    logic signed [TEMP_W-1:0] rec_outside_temp;
    logic signed [TEMP_W-1:0] rec_inside_temp;
    logic [HUM_W-1:0]         rec_humidity;
  } record_t;

endpackage

`default_nettype wire

@@ src/shrb_ram.sv @@
// ============================================================================
// shrb_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module shrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ src/shrb_hms.sv @@
// ============================================================================
// shrb_hms: time of day to hours, minutes and seconds
// Two divisions by 60 through a constant reciprocal; the minute total and
// the seconds are registered on load, hours and minutes follow from them.
// ============================================================================
`default_nettype none

module shrb_hms (
  input  wire logic                          clk,
  input  wire logic                          ld,
  input  wire logic [shrb_pkg::TIME_W-1:0]   time_of_day,
  output logic      [shrb_pkg::HOUR_W-1:0]   hour,
  output logic      [shrb_pkg::MIN_W-1:0]    minute,
  output logic      [shrb_pkg::SEC_W-1:0]    second
);

  import shrb_pkg::*;

  localparam int unsigned P1_W = TIME_W + DIV60_MUL_W;
  localparam int unsigned P2_W = MTOT_W + DIV60_MUL_W;

  logic [P1_W-1:0]   prod1;
  logic [MTOT_W-1:0] mtot;
  logic [TIME_W-1:0] mtot_x60;
  logic [TIME_W-1:0] sec_full;
  logic [MTOT_W-1:0] mtot_r;
  logic [SEC_W-1:0]  sec_r;
  logic [P2_W-1:0]   prod2;
  logic [HOUR_W-1:0] hr;
  logic [MTOT_W-1:0] hr_x60;
  logic [MTOT_W-1:0] min_full;

  always_comb begin
    prod1    = P1_W'(time_of_day) * P1_W'(DIV60_MUL);
    mtot     = prod1[DIV60_SHIFT +: MTOT_W];
    // q * 60 as q * 64 - q * 4.
    mtot_x60 = (TIME_W'(mtot) << 6) - (TIME_W'(mtot) << 2);
    sec_full = time_of_day - mtot_x60;
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      mtot_r <= mtot;
      sec_r  <= sec_full[SEC_W-1:0];
    end
  end

  always_comb begin
    prod2    = P2_W'(mtot_r) * P2_W'(DIV60_MUL);
    hr       = prod2[DIV60_SHIFT +: HOUR_W];
    hr_x60   = (MTOT_W'(hr) << 6) - (MTOT_W'(hr) << 2);
    min_full = mtot_r - hr_x60;
  end

  assign hour   = hr;
  assign minute = min_full[MIN_W-1:0];
  assign second = sec_r;

endmodule

`default_nettype wire

@@ src/sampled_history_ring_buffer.sv @@
// ============================================================================
// sampled_history_ring_buffer: sensor history logger on an overwriting ring
//
// Input channel (in_valid / in_ready): one beat per action. A packet beat
// (action 0) is checked, split into hours, minutes and seconds and stored
// when at least 43200/DEPTH seconds passed since the last stored record.
// A read beat (action 1) returns the record at a logical index, 0 newest.
// Result channel (out_valid / out_ready): exactly one beat per input beat.
// One item at a time: the result passes from the item register through the
// status and record registers. The controller accepts an item,
// performs the single read-modify-write pass on the record memories, then
// loads the output register. The next item is taken while a result waits.
// A stalled receiver holds the output register; the controller then waits
// in its last step before it can overwrite that result.
// Reset clears the write pointer, the held count and the last store time.
// The record memories are not cleared: only entries below the held count
// are ever read, so no clearing pass is needed.
// ============================================================================
`default_nettype none

module sampled_history_ring_buffer #(
  parameter int unsigned DEPTH = shrb_pkg::DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_action,
  input  wire logic        [shrb_pkg::ID_W-1:0]    in_sender_id,
  input  wire logic        [shrb_pkg::TIME_W-1:0]  in_time_of_day,
  input  wire logic signed [shrb_pkg::TEMP_W-1:0]  in_outside_temp,
  input  wire logic signed [shrb_pkg::TEMP_W-1:0]  in_inside_temp,
  input  wire logic        [shrb_pkg::HUM_W-1:0]   in_inside_humidity,
  input  wire logic        [shrb_pkg::IDX_W-1:0]   in_read_age,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic             [shrb_pkg::STATUS_W-1:0] out_status,
  output logic             [shrb_pkg::HOUR_W-1:0]  out_hour,
  output logic             [shrb_pkg::MIN_W-1:0]   out_minute,
  output logic             [shrb_pkg::SEC_W-1:0]   out_second,
  output logic             [shrb_pkg::ID_W-1:0]    out_rec_id,
  output logic             [shrb_pkg::TIME_W-1:0]  out_rec_time,
  output logic signed      [shrb_pkg::TEMP_W-1:0]  out_rec_outside_temp,
  output logic signed      [shrb_pkg::TEMP_W-1:0]  out_rec_inside_temp,
  output logic             [shrb_pkg::HUM_W-1:0]   out_rec_humidity,
  output logic             [shrb_pkg::FILL_W-1:0]  out_fill_count
);

  import shrb_pkg::*;

  localparam int unsigned PW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned EXTW = (CW > FILL_W) ? CW : FILL_W;
  localparam int unsigned SW   = ((PW + 1 > IDX_W) ? PW + 1 : IDX_W) + 1;
  localparam int unsigned IT_W = ID_W + TIME_W;
  localparam int unsigned RD_W = 2 * TEMP_W + HUM_W;
  localparam logic signed [TIME_W:0] INTERVAL = (TIME_W + 1)'(DAY_HALF_SECONDS / DEPTH);

  state_t state_r, state_nxt;

  item_t             item_r;
  logic [PW-1:0]     wp_r, wp_nxt;
  logic [CW-1:0]     held_r, held_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;

  logic              in_fire;
  logic              calc_en;
  logic              emit_fire;

  // Read address of the newest-first index.
  logic [SW-1:0]     slot_sum;
  logic [SW-1:0]     slot_wrap;
  logic [PW-1:0]     rd_slot;

  logic [IT_W-1:0]   it_rdata;
  logic [RD_W-1:0]   rd_rdata;
  logic              pkt_ok;
  logic signed [TIME_W:0] time_diff;
  logic              store_hit;
  logic              mem_we;
  logic [EXTW-1:0]   held_ext;
  logic [EXTW-1:0]   held_nxt_ext;
  logic [EXTW-1:0]   idx_ext;

  logic [STATUS_W-1:0] status_c, status_r;
  record_t           rec_c, rec_r;
  logic [FILL_W-1:0] fill_r;

  logic [HOUR_W-1:0] hms_hour;
  logic [MIN_W-1:0]  hms_minute;
  logic [SEC_W-1:0]  hms_second;
  logic              show_time;

  logic              out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [HOUR_W-1:0] out_hour_r;
  logic [MIN_W-1:0]  out_minute_r;
  logic [SEC_W-1:0]  out_second_r;
  record_t           out_rec_r;
  logic [FILL_W-1:0] out_fill_r;

  // Controller: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: state_nxt = S_EMIT;
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Controller: outputs.
  always_comb begin
    in_ready  = 1'b0;
    calc_en   = 1'b0;
    emit_fire = 1'b0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_CALC: calc_en = 1'b1;
      S_EMIT: emit_fire = !out_valid_r || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  assign in_fire = in_valid && in_ready;

  always_comb begin
    slot_sum  = SW'(wp_r) + SW'(DEPTH - 1) - SW'(in_read_age);
    slot_wrap = (slot_sum >= SW'(DEPTH)) ? slot_sum - SW'(DEPTH) : slot_sum;
    rd_slot   = slot_wrap[PW-1:0];
  end

  shrb_ram #(
    .WIDTH (IT_W),
    .DEPTH (DEPTH)
  ) u_id_time_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wp_r),
    .wdata ({item_r.sender_id, item_r.time_of_day}),
    .re    (in_fire),
    .raddr (rd_slot),
    .rdata (it_rdata)
  );

  shrb_ram #(
    .WIDTH (RD_W),
    .DEPTH (DEPTH)
  ) u_reading_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wp_r),
    .wdata ({item_r.outside_temp, item_r.inside_temp, item_r.inside_humidity}),
    .re    (in_fire),
    .raddr (rd_slot),
    .rdata (rd_rdata)
  );

  shrb_hms u_hms (
    .clk         (clk),
    .ld          (calc_en),
    .time_of_day (item_r.time_of_day),
    .hour        (hms_hour),
    .minute      (hms_minute),
    .second      (hms_second)
  );

  // Read-modify-write pass on the ring state.
  always_comb begin
    pkt_ok = (item_r.sender_id != '0) && (item_r.time_of_day != '0)
          && (item_r.time_of_day <= TIME_W'(LAST_TIME_OF_DAY));
    // Times going backwards give a negative difference and never store.
    time_diff = $signed({1'b0, item_r.time_of_day}) - $signed({1'b0, last_r});
    store_hit = (item_r.action == ACT_PACKET) && pkt_ok && (time_diff >= INTERVAL);
    mem_we    = calc_en && store_hit;

    wp_nxt   = wp_r;
    held_nxt = held_r;
    last_nxt = last_r;
    if (mem_we) begin
      wp_nxt   = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      held_nxt = (held_r == CW'(DEPTH)) ? held_r : held_r + CW'(1);
      last_nxt = item_r.time_of_day;
    end

    held_ext     = EXTW'(held_r);
    held_nxt_ext = EXTW'(held_nxt);
    idx_ext      = EXTW'(item_r.read_age);

    rec_c = '0;
    if (item_r.action == ACT_READ) begin
      if (idx_ext >= held_ext) begin
        status_c = ST_RANGE;
      end else begin
        status_c               = ST_READ_OK;
        rec_c.rec_id           = it_rdata[TIME_W +: ID_W];
        rec_c.rec_time         = it_rdata[TIME_W-1:0];
        rec_c.rec_outside_temp = rd_rdata[TEMP_W + HUM_W +: TEMP_W];
        rec_c.rec_inside_temp  = rd_rdata[HUM_W +: TEMP_W];
        rec_c.rec_humidity     = rd_rdata[HUM_W-1:0];
      end
    end else if (!pkt_ok) begin
      status_c = ST_INVALID;
    end else if (store_hit) begin
      status_c = ST_STORED;
    end else begin
      status_c = ST_TOO_SOON;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    show_time = (status_r == ST_STORED) || (status_r == ST_TOO_SOON);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      held_r      <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      held_r      <= held_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.action          <= in_action;
      item_r.sender_id       <= in_sender_id;
      item_r.time_of_day     <= in_time_of_day;
      item_r.outside_temp    <= in_outside_temp;
      item_r.inside_temp     <= in_inside_temp;
      item_r.inside_humidity <= in_inside_humidity;
      item_r.read_age        <= in_read_age;
    end
    if (calc_en) begin
      status_r <= status_c;
      rec_r    <= rec_c;
      fill_r   <= held_nxt_ext[FILL_W-1:0];
    end
    if (emit_fire) begin
      out_status_r <= status_r;
      out_hour_r   <= show_time ? hms_hour : '0;
      out_minute_r <= show_time ? hms_minute : '0;
      out_second_r <= show_time ? hms_second : '0;
      out_rec_r    <= rec_r;
      out_fill_r   <= fill_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_hour             = out_hour_r;
  assign out_minute           = out_minute_r;
  assign out_second           = out_second_r;
  assign out_rec_id           = out_rec_r.rec_id;
  assign out_rec_time         = out_rec_r.rec_time;
  assign out_rec_outside_temp = out_rec_r.rec_outside_temp;
  assign out_rec_inside_temp  = out_rec_r.rec_inside_temp;
  assign out_rec_humidity     = out_rec_r.rec_humidity;
  assign out_fill_count       = out_fill_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(DEPTH))
    else $error("held count exceeds ring depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= PW'(DEPTH - 1))
    else $error("write pointer beyond last slot");

  a_store_advances: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (wp_r != $past(wp_r)) && (last_r == $past(item_r.time_of_day)))
    else $error("store did not advance the ring state");

  a_nostore_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (calc_en && !store_hit) |=> $stable(wp_r) && $stable(held_r) && $stable(last_r))
    else $error("ring state changed without a store");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> out_valid_r && (state_r == S_IDLE))
    else $error("result not presented after emit");

endmodule

`default_nettype wire
